// ===== hw/rtl/ple_pkg.sv =====
// Package for the positional list engine.
// Field widths, opcode, status and sequencer state types; no dependencies.
package ple_pkg;

   localparam int OPCODE_W   = 2;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 5;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 4;
   localparam int LENGTH_W   = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_FIND,
      OP_NOP
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_EMPTY,
      STATUS_BAD_POSITION,
      STATUS_NOT_FOUND
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_DELETE,
      ST_FIND,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/ple_if.sv =====
// Valid/ready channel interfaces for list commands and their results.
// Depends on ple_pkg for the field widths.
interface ple_req_if import ple_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic        [OPCODE_W-1:0]   opcode;
   logic signed [VALUE_W-1:0]    value;
   logic        [POSITION_W-1:0] position;

   modport source (output valid, output opcode, output value, output position, input ready);
   modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [INDEX_W-1:0]    found_index;
   logic [LENGTH_W-1:0]   list_length;

   modport source (output valid, output status, output found_index, output list_length,
                   input ready);
   modport sink   (input valid, input status, input found_index, input list_length,
                   output ready);
endinterface

// ===== hw/rtl/positional_list_engine_top.sv =====
// Positional list engine: ordered list of signed values held in one RAM.
// Depends on ple_pkg, ple_req_if, ple_rsp_if and ple_ram.
// One transaction at a time; the RAM port walks one entry per cycle.
// Insert shifts the tail up, delete shifts it down, find scans from the head;
// the reply waits while the reply channel stalls.
// Synchronous reset empties the list at once; RAM contents are left as they are.
module positional_list_engine_top import ple_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_chan,
   ple_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [AW-1:0]        base_ff, base_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic [CW-1:0]        count_ff, count_in;
   status_type           res_status_ff, res_status_in;
   logic [AW-1:0]        res_index_ff, res_index_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [LENGTH_W-1:0]  rsp_length_ff, rsp_length_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic [VALUE_W-1:0]   rd_data;

   logic [XW-1:0]        pos_x;
   logic [XW-1:0]        cnt_x;
   logic                 accept;
   logic                 out_free;

   ple_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign accept               = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free             = !rsp_valid_ff || rsp_chan.ready;
   assign pos_x                = XW'(req_chan.position);
   assign cnt_x                = XW'(count_ff);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_index = rsp_index_ff;
   assign rsp_chan.list_length = rsp_length_ff;

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      rem_in        = rem_ff;
      pend_in       = 1'b0;
      pend_addr_in  = addr_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_length_in = rsp_length_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in      = req_chan.value;
               base_in       = AW'(pos_x - XW'(1));
               res_index_in  = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
               case (opcode_type'(req_chan.opcode))
                  OP_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = STATUS_FULL;
                     end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                        res_status_in = STATUS_BAD_POSITION;
                     end else begin
                        rem_in   = CW'(cnt_x - pos_x + XW'(1));
                        addr_in  = AW'(cnt_x - XW'(1));
                        state_in = ST_INSERT;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else if (pos_x == '0 || pos_x > cnt_x) begin
                        res_status_in = STATUS_BAD_POSITION;
                     end else begin
                        rem_in   = CW'(cnt_x - pos_x);
                        addr_in  = AW'(pos_x);
                        state_in = ST_DELETE;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rem_in   = count_ff;
                        addr_in  = '0;
                        state_in = ST_FIND;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff + AW'(1);
               wr_data = rd_data;
            end else if (rem_ff == '0) begin
               wr_en         = 1'b1;
               wr_addr       = base_ff;
               wr_data       = value_ff;
               count_in      = count_ff + CW'(1);
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end
            if (rem_ff != '0) begin
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
               addr_in      = addr_ff - AW'(1);
               rem_in       = rem_ff - CW'(1);
            end
         end
         ST_DELETE: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff - AW'(1);
               wr_data = rd_data;
            end else if (rem_ff == '0) begin
               count_in      = count_ff - CW'(1);
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end
            if (rem_ff != '0) begin
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
               addr_in      = addr_ff + AW'(1);
               rem_in       = rem_ff - CW'(1);
            end
         end
         ST_FIND: begin
            if (pend_ff && rd_data == value_ff) begin
               res_status_in = STATUS_OK;
               res_index_in  = pend_addr_ff;
               state_in      = ST_DONE;
            end else if (!pend_ff && rem_ff == '0) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_DONE;
            end else if (rem_ff != '0) begin
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
               addr_in      = addr_ff + AW'(1);
               rem_in       = rem_ff - CW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = INDEX_W'(res_index_ff);
               rsp_length_in = LENGTH_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      base_ff       <= base_in;
      addr_ff       <= addr_in;
      rem_ff        <= rem_in;
      pend_addr_ff  <= pend_addr_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_length_ff <= rsp_length_in;
   end

endmodule

// ===== hw/rtl/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
